// ----- hw/rtl/qrs_pkg.sv -----
// Shared types and constants for the quadratic root solver.
// No dependencies.
package qrs_pkg;

  localparam int ROOT_WIDTH = 34;
  localparam int CNT_WIDTH  = 2;

  localparam logic [CNT_WIDTH-1:0] CNT_NONE = 2'd0;
  localparam logic [CNT_WIDTH-1:0] CNT_ONE  = 2'd1;
  localparam logic [CNT_WIDTH-1:0] CNT_TWO  = 2'd2;

  // control that travels with each beat down the cell chains
  typedef struct packed {
    logic                 valid;
    logic [CNT_WIDTH-1:0] cnt;
  } ctl_t;

endpackage

// ----- hw/rtl/quadratic_root_solver.sv -----
// Quadratic root solver top level: operand stages, square root and divider chains.
// Depends on qrs_pkg, qrs_sqrt_cell, qrs_div_cell.
//
// Takes one coefficient set per clock and never stalls (busy stays low). Each set
// yields one result beat, marked by done. The path from start to done runs through
// the square root cell chain (one root bit per cell), one of the two parallel divider
// cell chains (one quotient bit per cell) and five register stages: input, product,
// square root load, divider load and output; results cannot be held off by the receiver.
module quadratic_root_solver #(
  parameter int COEF_WIDTH = 16,
  parameter int FRAC_BITS  = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  logic signed [COEF_WIDTH-1:0]          coef_quad,
  input  logic signed [COEF_WIDTH-1:0]          coef_lin,
  input  logic signed [COEF_WIDTH-1:0]          coef_const,
  output logic                                  done,
  output logic [qrs_pkg::CNT_WIDTH-1:0]         root_count,
  output logic signed [qrs_pkg::ROOT_WIDTH-1:0] root_first,
  output logic signed [qrs_pkg::ROOT_WIDTH-1:0] root_second
);
  import qrs_pkg::*;

  localparam int W    = COEF_WIDTH;
  localparam int F    = FRAC_BITS;
  localparam int DW   = 2 * W + 1;            // discriminant
  localparam int SQ   = (DW + 1) / 2 + F;     // root bits
  localparam int XW   = 2 * SQ;
  localparam int NW   = SQ + 1;               // numerator magnitude
  localparam int BW   = W + F + 1;            // -b or -c scaled
  localparam int DSW  = W + 2;                // signed denominator
  localparam int DNW  = W + 1;                // denominator magnitude
  localparam int SW   = DSW + BW;
  localparam int QW   = NW > ROOT_WIDTH ? NW : ROOT_WIDTH;
  localparam int LAT  = SQ + NW + 5;

  assign busy = 1'b0;

  // input stage
  logic                v_p;
  logic signed [W-1:0] a_p, b_p, c_p;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_p <= 1'b0;
    end else begin
      v_p <= start;
    end
    a_p <= coef_quad;
    b_p <= coef_lin;
    c_p <= coef_const;
  end

  // product stage
  logic [W-1:0]        am, bm, cm;
  logic                v_m;
  logic signed [W-1:0] a_m, b_m, c_m;
  logic [2*W-1:0]      bb_m, ac_m;

  assign am = a_p[W-1] ? W'(-a_p) : W'(a_p);
  assign bm = b_p[W-1] ? W'(-b_p) : W'(b_p);
  assign cm = c_p[W-1] ? W'(-c_p) : W'(c_p);

  always_ff @(posedge clk) begin
    if (rst) begin
      v_m <= 1'b0;
    end else begin
      v_m <= v_p;
    end
    a_m  <= a_p;
    b_m  <= b_p;
    c_m  <= c_p;
    bb_m <= bm * bm;
    ac_m <= am * cm;
  end

  // discriminant and case selection
  logic [DW-1:0]         bbx, ac4, dsum, dval;
  logic [DW:0]           ddiff;
  logic                  ac_neg;
  logic [CNT_WIDTH-1:0]  cnt_d;
  logic signed [BW-1:0]  bx, cx, base_d;
  logic signed [DSW-1:0] den_d;

  assign bbx    = DW'(bb_m);
  assign ac4    = DW'({ac_m, 2'b00});
  assign dsum   = bbx + ac4;
  assign ddiff  = {1'b0, bbx} - {1'b0, ac4};
  assign ac_neg = a_m[W-1] ^ c_m[W-1];
  assign bx     = BW'(b_m);
  assign cx     = BW'(c_m);

  always_comb begin
    dval = '0;
    if (a_m == '0) begin
      base_d = -(cx <<< F);
      den_d  = DSW'(b_m);
      cnt_d  = (b_m == '0) ? CNT_NONE : CNT_ONE;
    end else begin
      base_d = -(bx <<< F);
      den_d  = DSW'(a_m) <<< 1;
      if (ac_neg) begin
        dval  = dsum;
        cnt_d = (dsum == '0) ? CNT_ONE : CNT_TWO;
      end else if (ddiff[DW]) begin
        cnt_d = CNT_NONE;
      end else begin
        dval  = ddiff[DW-1:0];
        cnt_d = (ddiff == '0) ? CNT_ONE : CNT_TWO;
      end
    end
  end

  ctl_t              sq_ctl  [SQ+1];
  logic [XW-1:0]     sq_x    [SQ+1];
  logic [SQ-1:0]     sq_rem  [SQ+1];
  logic [SQ-1:0]     sq_root [SQ+1];
  logic [SW-1:0]     sq_side [SQ+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_ctl[0] <= '0;
    end else begin
      sq_ctl[0] <= '{valid: v_m, cnt: cnt_d};
    end
    sq_x[0]    <= XW'(dval) << (2 * F);
    sq_rem[0]  <= '0;
    sq_root[0] <= '0;
    sq_side[0] <= {den_d, base_d};
  end

  for (genvar k = 0; k < SQ; k++) begin : g_sqrt
    qrs_sqrt_cell #(.SQ(SQ), .XW(XW), .SIDE_W(SW)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .in_ctl   (sq_ctl[k]),
      .in_x     (sq_x[k]),
      .in_rem   (sq_rem[k]),
      .in_root  (sq_root[k]),
      .in_side  (sq_side[k]),
      .out_ctl  (sq_ctl[k+1]),
      .out_x    (sq_x[k+1]),
      .out_rem  (sq_rem[k+1]),
      .out_root (sq_root[k+1]),
      .out_side (sq_side[k+1])
    );
  end

  // numerator stage: base +/- sqrt, split into magnitude and sign
  logic signed [NW:0]    basex, sx, num1, num2;
  logic signed [DSW-1:0] den_n;
  logic signed [BW-1:0]  base_n;

  assign den_n  = sq_side[SQ][SW-1:BW];
  assign base_n = sq_side[SQ][BW-1:0];
  assign basex  = (NW+1)'(base_n);
  assign sx     = $signed({{(NW+1-SQ){1'b0}}, sq_root[SQ]});
  assign num1   = basex + sx;
  assign num2   = basex - sx;

  ctl_t           dv_ctl  [2][NW+1];
  logic [NW-1:0]  dv_nq   [2][NW+1];
  logic [DNW-1:0] dv_rem  [2][NW+1];
  logic [DNW-1:0] dv_den  [2][NW+1];
  logic [0:0]     dv_neg  [2][NW+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_ctl[0][0] <= '0;
      dv_ctl[1][0] <= '0;
    end else begin
      dv_ctl[0][0] <= sq_ctl[SQ];
      dv_ctl[1][0] <= sq_ctl[SQ];
    end
    dv_nq[0][0]  <= NW'(num1[NW] ? -num1 : num1);
    dv_nq[1][0]  <= NW'(num2[NW] ? -num2 : num2);
    dv_rem[0][0] <= '0;
    dv_rem[1][0] <= '0;
    dv_den[0][0] <= DNW'(den_n[DSW-1] ? -den_n : den_n);
    dv_den[1][0] <= DNW'(den_n[DSW-1] ? -den_n : den_n);
    dv_neg[0][0] <= num1[NW] ^ den_n[DSW-1];
    dv_neg[1][0] <= num2[NW] ^ den_n[DSW-1];
  end

  for (genvar j = 0; j < 2; j++) begin : g_div
    for (genvar k = 0; k < NW; k++) begin : g_cell
      qrs_div_cell #(.NW(NW), .DNW(DNW), .SIDE_W(1)) u_cell (
        .clk      (clk),
        .rst      (rst),
        .in_ctl   (dv_ctl[j][k]),
        .in_nq    (dv_nq[j][k]),
        .in_rem   (dv_rem[j][k]),
        .in_den   (dv_den[j][k]),
        .in_side  (dv_neg[j][k]),
        .out_ctl  (dv_ctl[j][k+1]),
        .out_nq   (dv_nq[j][k+1]),
        .out_rem  (dv_rem[j][k+1]),
        .out_den  (dv_den[j][k+1]),
        .out_side (dv_neg[j][k+1])
      );
    end
  end

  // sign and output beat
  logic [QW-1:0]         q1, q2;
  logic [ROOT_WIDTH-1:0] res1, res2;
  ctl_t                  ctl_o;

  assign ctl_o = dv_ctl[0][NW];
  assign q1    = QW'(dv_nq[0][NW]);
  assign q2    = QW'(dv_nq[1][NW]);
  assign res1  = ROOT_WIDTH'(dv_neg[0][NW][0] ? -q1 : q1);
  assign res2  = ROOT_WIDTH'(dv_neg[1][NW][0] ? -q2 : q2);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl_o.valid;
    end
    root_count  <= ctl_o.cnt;
    root_first  <= (ctl_o.cnt == CNT_NONE) ? '0 : $signed(res1);
    root_second <= (ctl_o.cnt == CNT_TWO) ? $signed(res2) : '0;
  end

  a_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, LAT))
    else $error("result beat without a matching start");

  a_count: assert property (@(posedge clk) disable iff (rst)
    done |-> (root_count == CNT_NONE || root_count == CNT_ONE || root_count == CNT_TWO))
    else $error("bad root count");

  a_none_zero: assert property (@(posedge clk) disable iff (rst)
    done && root_count == CNT_NONE |-> root_first == '0 && root_second == '0)
    else $error("roots not cleared with no root");

  a_second_zero: assert property (@(posedge clk) disable iff (rst)
    done && root_count != CNT_TWO |-> root_second == '0)
    else $error("second root set without two roots");

endmodule

// ----- hw/rtl/qrs_sqrt_cell.sv -----
// One digit of a restoring square root: takes one radicand bit pair per beat.
// Depends on qrs_pkg.
module qrs_sqrt_cell #(
  parameter int SQ     = 33,
  parameter int XW     = 66,
  parameter int SIDE_W = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  qrs_pkg::ctl_t        in_ctl,
  input  logic [XW-1:0]        in_x,
  input  logic [SQ-1:0]        in_rem,
  input  logic [SQ-1:0]        in_root,
  input  logic [SIDE_W-1:0]    in_side,
  output qrs_pkg::ctl_t        out_ctl,
  output logic [XW-1:0]        out_x,
  output logic [SQ-1:0]        out_rem,
  output logic [SQ-1:0]        out_root,
  output logic [SIDE_W-1:0]    out_side
);
  import qrs_pkg::*;

  logic [SQ+1:0] rem2;
  logic [SQ+1:0] trial;
  logic          ge;

  assign rem2  = {in_rem, in_x[XW-1:XW-2]};
  assign trial = {in_root, 2'b01};
  assign ge    = rem2 >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ctl <= '0;
    end else begin
      out_ctl <= in_ctl;
    end
    // final remainder may exceed SQ bits; it is never used past the last cell
    out_rem  <= SQ'(ge ? rem2 - trial : rem2);
    out_root <= {in_root[SQ-2:0], ge};
    out_x    <= {in_x[XW-3:0], 2'b00};
    out_side <= in_side;
  end

endmodule

// ----- hw/rtl/qrs_div_cell.sv -----
// One quotient bit of a restoring unsigned divider.
// Depends on qrs_pkg.
module qrs_div_cell #(
  parameter int NW     = 34,
  parameter int DNW    = 17,
  parameter int SIDE_W = 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  qrs_pkg::ctl_t        in_ctl,
  input  logic [NW-1:0]        in_nq,
  input  logic [DNW-1:0]       in_rem,
  input  logic [DNW-1:0]       in_den,
  input  logic [SIDE_W-1:0]    in_side,
  output qrs_pkg::ctl_t        out_ctl,
  output logic [NW-1:0]        out_nq,
  output logic [DNW-1:0]       out_rem,
  output logic [DNW-1:0]       out_den,
  output logic [SIDE_W-1:0]    out_side
);
  import qrs_pkg::*;

  logic [DNW:0] r2;
  logic         ge;

  assign r2 = {in_rem, in_nq[NW-1]};
  assign ge = r2 >= {1'b0, in_den};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ctl <= '0;
    end else begin
      out_ctl <= in_ctl;
    end
    // numerator shifts out the top while quotient bits enter at the bottom
    out_rem  <= DNW'(ge ? r2 - {1'b0, in_den} : r2);
    out_nq   <= {in_nq[NW-2:0], ge};
    out_den  <= in_den;
    out_side <= in_side;
  end

endmodule
